FILE: sv/udpcs_pkg.sv
// udpcs_pkg: shared types, constants and helpers for the udp/ipv4 checksum generator
`default_nettype none
package udpcs_pkg;

    // input request: one payload word
    typedef struct packed {
        logic [15:0] payload_word;
        logic [1:0]  valid_bytes;
        logic        is_last;
    } in_item_t;

    // result: lengths, checksums and error flag of one datagram
    typedef struct packed {
        logic [15:0] udp_length;
        logic [15:0] udp_checksum;
        logic [15:0] ip_total_length;
        logic [15:0] ip_header_checksum;
        logic        length_error;
    } out_item_t;

    // finished payload totals handed from front to back
    typedef struct packed {
        logic [15:0] payload_sum;
        logic [16:0] byte_count;
    } job_t;

    // configuration register file contents
    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  ip_protocol_number;
    } cfg_t;

    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int QUEUE_DEPTH  = 4;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_ADDRESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_ADDRESS   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_PORT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_PORT      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IP_PROTOCOL    = 3'd4;

    // valid_bytes codes
    localparam logic [1:0] VB_NONE = 2'd0;
    localparam logic [1:0] VB_HIGH = 2'd1;
    localparam logic [1:0] VB_BOTH = 2'd2;
    localparam logic [1:0] VB_WIDE = 2'd3;

    localparam logic [7:0]  IP_PROTO_UDP       = 8'd17;
    localparam logic [16:0] COUNT_CEILING      = 17'h1FFFF;
    localparam logic [16:0] MAX_PAYLOAD_BYTES  = 17'd65507;
    localparam logic [16:0] UDP_HEADER_BYTES   = 17'd8;
    localparam logic [16:0] IP_UDP_HEADER_BYTES = 17'd28;
    localparam logic [15:0] LENGTH_CEILING     = 16'hFFFF;
    // version/ihl word, flags word (df set) and ttl byte of the ipv4 header
    localparam logic [15:0] IP_VER_IHL_WORD    = 16'h4500;
    localparam logic [15:0] IP_FLAGS_WORD      = 16'h4000;
    localparam logic [7:0]  IP_TTL             = 8'h40;

    // end-around carry fold of a sum of up to sixteen 16-bit words
    function automatic logic [15:0] ones_fold(input logic [19:0] value);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = {1'b0, value[15:0]} + {13'd0, value[19:16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        return f2[15:0];
    endfunction

endpackage
`default_nettype wire

FILE: sv/udp_ipv4_header_checksum_gen_top.sv
// udp_ipv4_header_checksum_gen_top: udp/ipv4 length and checksum generator top level
//
//   channel   ports                              moves
//   payload   s_valid s_ready s_data             one 16-bit payload word per request
//   result    m_valid m_ready m_data             lengths and checksums per datagram
//   config    cfg_valid cfg_ready cfg_index      one register write per request
//             cfg_data
//
// one payload word is taken every cycle while s_ready is high; the front
// accumulator does one 16-bit end-around-carry add per word. a datagram result
// passes a four-entry queue and three pipeline stages after its last word is taken.
// s_ready drops only while the queue holds QUEUE_DEPTH finished datagrams that
// the stalled result side has not drained. reset clears the accumulators, the
// queue and the pipeline at once and loads the register reset values.
`default_nettype none
module udp_ipv4_header_checksum_gen_top
    import udpcs_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_item_t               s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_item_t                   m_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    logic     q_full;
    logic     q_push;
    job_t     q_job;
    job_t     pop_job;
    logic     q_pop_valid;
    logic     q_pop_ready;

    // register file, writes always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SOURCE_ADDRESS: cfg_next.source_address     = cfg_data;
                CFG_DEST_ADDRESS:   cfg_next.dest_address       = cfg_data;
                CFG_SOURCE_PORT:    cfg_next.source_port        = cfg_data[15:0];
                CFG_DEST_PORT:      cfg_next.dest_port          = cfg_data[15:0];
                CFG_IP_PROTOCOL:    cfg_next.ip_protocol_number = cfg_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_address     <= 32'd0;
            cfg_reg.dest_address       <= 32'd0;
            cfg_reg.source_port        <= 16'd0;
            cfg_reg.dest_port          <= 16'd0;
            cfg_reg.ip_protocol_number <= IP_PROTO_UDP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // accumulate payload words
    udpcs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_job)
    );

    // finished datagram totals
    udpcs_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (q_job),
        .full      (q_full),
        .pop_ready (q_pop_ready),
        .pop_valid (q_pop_valid),
        .pop_job   (pop_job)
    );

    // checksum back end
    udpcs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_job   (pop_job),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

FILE: sv/udpcs_front.sv
// udpcs_front: accepts payload words, keeps running sum and byte count, queues totals
`default_nettype none
module udpcs_front
    import udpcs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    input  wire logic     q_full,
    output logic          q_push,
    output job_t          q_job
);

    logic [15:0] sum_reg,   sum_next;
    logic [16:0] count_reg, count_next;
    logic        odd_reg,   odd_next;

    logic        accept;
    logic [15:0] contrib;
    logic [1:0]  add_n;
    logic [7:0]  hi_byte;
    logic [7:0]  lo_byte;
    logic [16:0] sum_raw;
    logic [15:0] sum_upd;
    logic [17:0] count_sum;
    logic [16:0] count_upd;
    logic        odd_upd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign hi_byte = s_data.payload_word[15:8];
    assign lo_byte = s_data.payload_word[7:0];

    // word contribution, swapped when an odd byte came before
    always_comb begin
        contrib = 16'd0;
        add_n   = 2'd0;
        odd_upd = odd_reg;
        unique case (s_data.valid_bytes)
            VB_BOTH, VB_WIDE: begin
                contrib = odd_reg ? {lo_byte, hi_byte} : s_data.payload_word;
                add_n   = 2'd2;
            end
            VB_HIGH: begin
                contrib = odd_reg ? {8'd0, hi_byte} : {hi_byte, 8'd0};
                add_n   = 2'd1;
                odd_upd = !odd_reg;
            end
            VB_NONE: begin
                contrib = 16'd0;
                add_n   = 2'd0;
            end
            default: begin
                contrib = 16'd0;
                add_n   = 2'd0;
            end
        endcase
    end

    // ones' complement add and saturating count
    assign sum_raw   = {1'b0, sum_reg} + {1'b0, contrib};
    assign sum_upd   = ones_fold({3'd0, sum_raw});
    assign count_sum = {1'b0, count_reg} + {16'd0, add_n};
    assign count_upd = (count_sum > {1'b0, COUNT_CEILING}) ? COUNT_CEILING
                                                           : count_sum[16:0];

    // hand totals to the queue on the last word
    assign q_push            = accept && s_data.is_last;
    assign q_job.payload_sum = sum_upd;
    assign q_job.byte_count  = count_upd;

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        odd_next   = odd_reg;
        if (accept) begin
            if (s_data.is_last) begin
                sum_next   = 16'd0;
                count_next = 17'd0;
                odd_next   = 1'b0;
            end else begin
                sum_next   = sum_upd;
                count_next = count_upd;
                odd_next   = odd_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= 16'd0;
            count_reg <= 17'd0;
            odd_reg   <= 1'b0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            odd_reg   <= odd_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/udpcs_queue.sv
// udpcs_queue: short fifo of finished payload totals between front and back
`default_nettype none
module udpcs_queue
    import udpcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire job_t     push_job,
    output logic          full,
    input  wire logic     pop_ready,
    output logic          pop_valid,
    output job_t          pop_job
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR   = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    job_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic               pop;

    assign full      = (count_reg == FULL_COUNT);
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_job   = mem[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

FILE: sv/udpcs_back.sv
// udpcs_back: back end, takes queued totals into the checksum pipeline
`default_nettype none
module udpcs_back
    import udpcs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cfg_t      cfg,
    input  wire job_t      pop_job,
    input  wire logic      pop_valid,
    output logic           pop_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    // lengths and both checksums
    udpcs_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .pop_job   (pop_job),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

FILE: sv/udpcs_engine.sv
// udpcs_engine: three-stage pipeline building lengths and both checksums
`default_nettype none
module udpcs_engine
    import udpcs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire job_t     pop_job,
    input  wire logic     pop_valid,
    output logic          pop_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    // stage one: lengths and partial sums
    logic        st1_valid_reg, st1_valid_next;
    logic [15:0] st1_sum_reg;
    logic [15:0] st1_ulen_reg;
    logic [15:0] st1_tlen_reg;
    logic        st1_err_reg;
    logic [17:0] st1_addr_reg;
    logic [17:0] st1_port_reg;

    // stage two: full sums before folding
    logic        st2_valid_reg, st2_valid_next;
    logic [19:0] st2_udp_reg;
    logic [19:0] st2_ip_reg;
    logic [15:0] st2_ulen_reg;
    logic [15:0] st2_tlen_reg;
    logic        st2_err_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg;

    logic        out_take;
    logic        st2_ready;
    logic        st1_ready;
    logic        pop;

    logic [17:0] ulen_wide;
    logic [17:0] tlen_wide;
    logic [15:0] ulen_sat;
    logic [15:0] tlen_sat;
    logic        err_flag;
    logic [17:0] addr_sum;
    logic [17:0] port_sum;
    logic [19:0] udp_total;
    logic [19:0] ip_total;
    logic [15:0] udp_fold;
    logic [15:0] ip_fold;
    logic [15:0] udp_csum;

    // stall chain: a stage moves when the one after it has room
    assign out_take  = !out_valid_reg || m_ready;
    assign st2_ready = !st2_valid_reg || out_take;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign pop       = pop_valid && st1_ready;

    assign pop_ready = st1_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // saturating lengths and oversize flag
    assign ulen_wide = {1'b0, pop_job.byte_count} + {1'b0, UDP_HEADER_BYTES};
    assign tlen_wide = {1'b0, pop_job.byte_count} + {1'b0, IP_UDP_HEADER_BYTES};
    assign ulen_sat  = (ulen_wide[17:16] != 2'd0) ? LENGTH_CEILING : ulen_wide[15:0];
    assign tlen_sat  = (tlen_wide[17:16] != 2'd0) ? LENGTH_CEILING : tlen_wide[15:0];
    assign err_flag  = (pop_job.byte_count > MAX_PAYLOAD_BYTES);

    // address words and ports with the udp protocol number
    assign addr_sum = {2'd0, cfg.source_address[31:16]} + {2'd0, cfg.source_address[15:0]}
                    + {2'd0, cfg.dest_address[31:16]}   + {2'd0, cfg.dest_address[15:0]};
    assign port_sum = {2'd0, cfg.source_port} + {2'd0, cfg.dest_port}
                    + {10'd0, IP_PROTO_UDP};

    // pseudo-header, ports, length twice and payload; ipv4 header words
    assign udp_total = {4'd0, st1_sum_reg} + {2'd0, st1_addr_reg} + {2'd0, st1_port_reg}
                     + {3'd0, st1_ulen_reg, 1'b0};
    assign ip_total  = {4'd0, IP_VER_IHL_WORD} + {4'd0, IP_FLAGS_WORD}
                     + {4'd0, IP_TTL, cfg.ip_protocol_number}
                     + {4'd0, st1_tlen_reg} + {2'd0, st1_addr_reg};

    // fold, complement, zero udp checksum sent as all ones
    assign udp_fold = ones_fold(st2_udp_reg);
    assign ip_fold  = ones_fold(st2_ip_reg);
    assign udp_csum = (udp_fold == 16'hFFFF) ? 16'hFFFF : ~udp_fold;

    always_comb begin
        st1_valid_next = st1_ready ? pop_valid : st1_valid_reg;
        st2_valid_next = st2_ready ? st1_valid_reg : st2_valid_reg;
        out_valid_next = out_take ? st2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (pop) begin
            st1_sum_reg  <= pop_job.payload_sum;
            st1_ulen_reg <= ulen_sat;
            st1_tlen_reg <= tlen_sat;
            st1_err_reg  <= err_flag;
            st1_addr_reg <= addr_sum;
            st1_port_reg <= port_sum;
        end
        if (st2_ready && st1_valid_reg) begin
            st2_udp_reg  <= udp_total;
            st2_ip_reg   <= ip_total;
            st2_ulen_reg <= st1_ulen_reg;
            st2_tlen_reg <= st1_tlen_reg;
            st2_err_reg  <= st1_err_reg;
        end
        if (out_take && st2_valid_reg) begin
            out_data_reg.udp_length         <= st2_ulen_reg;
            out_data_reg.udp_checksum       <= udp_csum;
            out_data_reg.ip_total_length    <= st2_tlen_reg;
            out_data_reg.ip_header_checksum <= ~ip_fold;
            out_data_reg.length_error       <= st2_err_reg;
        end
    end

endmodule
`default_nettype wire

FILE: bench/udp_ipv4_header_checksum_gen_top_tb.sv
// self-checking testbench for the udp/ipv4 length and checksum generator
import udpcs_pkg::*;

// scoreboard: tracks the open datagram and the results still owed by the block
class checksum_scoreboard;
    // register file as the block should hold it
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  ip_protocol_number;

    // payload accumulation of the datagram in progress
    logic [15:0] payload_sum;
    logic [16:0] payload_bytes;
    bit          odd_phase;

    out_item_t   expected_results[$];
    int          mismatches;

    function new();
        source_address     = '0;
        dest_address       = '0;
        source_port        = '0;
        dest_port          = '0;
        ip_protocol_number = IP_PROTO_UDP;
        payload_sum        = '0;
        payload_bytes      = '0;
        odd_phase          = 1'b0;
        mismatches         = 0;
    endfunction

    // 16-bit add with end-around carry
    function logic [15:0] add_ones(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // both addresses, four words, shared by the pseudo-header and the ip header
    function logic [15:0] add_addresses(input logic [15:0] s);
        logic [15:0] acc;
        acc = add_ones(s, source_address[31:16]);
        acc = add_ones(acc, source_address[15:0]);
        acc = add_ones(acc, dest_address[31:16]);
        acc = add_ones(acc, dest_address[15:0]);
        return acc;
    endfunction

    function void set_register(input logic [CFG_INDEX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] value);
        case (index)
            CFG_SOURCE_ADDRESS: source_address = value;
            CFG_DEST_ADDRESS:   dest_address = value;
            CFG_SOURCE_PORT:    source_port = value[15:0];
            CFG_DEST_PORT:      dest_port = value[15:0];
            CFG_IP_PROTOCOL:    ip_protocol_number = value[7:0];
            default: ;
        endcase
    endfunction

    // fold one accepted request into the datagram, queue a result on the last one
    function void note_request(input in_item_t req);
        logic [1:0]  vb;
        logic [15:0] word;
        logic [15:0] part;
        logic [15:0] sum;
        logic [17:0] total;
        logic [1:0]  nbytes;
        out_item_t   res;
        vb     = (req.valid_bytes == VB_WIDE) ? VB_BOTH : req.valid_bytes;
        word   = req.payload_word;
        nbytes = 2'd0;
        part   = 16'h0000;
        if (vb == VB_BOTH) begin
            // after an odd byte the word straddles two sum positions
            part   = odd_phase ? {word[7:0], word[15:8]} : word;
            nbytes = 2'd2;
        end else if (vb == VB_HIGH) begin
            part      = odd_phase ? {8'h00, word[15:8]} : {word[15:8], 8'h00};
            nbytes    = 2'd1;
            odd_phase = !odd_phase;
        end
        if (nbytes != 2'd0) begin
            payload_sum   = add_ones(payload_sum, part);
            total         = {1'b0, payload_bytes} + {16'd0, nbytes};
            payload_bytes = (total > {1'b0, COUNT_CEILING}) ? COUNT_CEILING : total[16:0];
        end
        if (!req.is_last)
            return;

        // lengths saturate, the checksums use the saturated values
        res.length_error = (payload_bytes > MAX_PAYLOAD_BYTES);
        total = {1'b0, payload_bytes} + {1'b0, UDP_HEADER_BYTES};
        res.udp_length = (total > 18'h0FFFF) ? LENGTH_CEILING : total[15:0];
        total = {1'b0, payload_bytes} + {1'b0, IP_UDP_HEADER_BYTES};
        res.ip_total_length = (total > 18'h0FFFF) ? LENGTH_CEILING : total[15:0];

        // pseudo-header, ports, udp length and payload
        sum = add_addresses(payload_sum);
        sum = add_ones(sum, {8'h00, IP_PROTO_UDP});
        sum = add_ones(sum, res.udp_length);
        sum = add_ones(sum, source_port);
        sum = add_ones(sum, dest_port);
        sum = add_ones(sum, res.udp_length);
        // zero means no checksum on the wire, so it goes out as all ones
        res.udp_checksum = (sum == 16'hFFFF) ? 16'hFFFF : ~sum;

        // ipv4 header, ident and checksum words are zero
        sum = add_ones(IP_VER_IHL_WORD, res.ip_total_length);
        sum = add_ones(sum, IP_FLAGS_WORD);
        sum = add_ones(sum, {IP_TTL, ip_protocol_number});
        sum = add_addresses(sum);
        res.ip_header_checksum = ~sum;

        expected_results.push_back(res);
        payload_sum   = '0;
        payload_bytes = '0;
        odd_phase     = 1'b0;
    endfunction

    // compare one result with the oldest expectation
    function void check_result(input out_item_t got);
        out_item_t exp;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: ulen %h ucs %h tlen %h ics %h err %b",
                         got.udp_length, got.udp_checksum, got.ip_total_length,
                         got.ip_header_checksum, got.length_error);
            return;
        end
        exp = expected_results.pop_front();
        if (got.udp_length !== exp.udp_length || got.udp_checksum !== exp.udp_checksum ||
            got.ip_total_length !== exp.ip_total_length ||
            got.ip_header_checksum !== exp.ip_header_checksum ||
            got.length_error !== exp.length_error) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result mismatch at %0t", $time);
                $display("  expected ulen %h ucs %h tlen %h ics %h err %b",
                         exp.udp_length, exp.udp_checksum, exp.ip_total_length,
                         exp.ip_header_checksum, exp.length_error);
                $display("  actual   ulen %h ucs %h tlen %h ics %h err %b",
                         got.udp_length, got.udp_checksum, got.ip_total_length,
                         got.ip_header_checksum, got.length_error);
            end
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module udp_ipv4_header_checksum_gen_top_tb;

    localparam int IDLE_LIMIT = 1000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_item_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    checksum_scoreboard board;
    bit source_idle = 1'b0;
    bit sink_idle = 1'b0;
    int idle_cycles = 0;
    int phase_items = 0;

    udp_ipv4_header_checksum_gen_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // result side back-pressure in random bursts
    initial begin
        @(negedge aclk);
        forever begin
            if (sink_idle && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    // every result handed over is checked
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_data);
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("udp_ipv4_header_checksum_gen_top_tb failed");
            $finish;
        end
    end

    // one payload request, with an optional gap in front of it
    task automatic send_word(input logic [15:0] word, input logic [1:0] vb, input bit last);
        in_item_t req;
        req.payload_word = word;
        req.valid_bytes  = vb;
        req.is_last      = last;
        @(negedge aclk);
        if (source_idle && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        board.note_request(req);
        phase_items++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.set_register(index, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input logic [31:0] src, input logic [31:0] dst,
                               input logic [15:0] sport, input logic [15:0] dport,
                               input logic [7:0] proto);
        write_reg(CFG_SOURCE_ADDRESS, src);
        write_reg(CFG_DEST_ADDRESS, dst);
        write_reg(CFG_SOURCE_PORT, {16'd0, sport});
        write_reg(CFG_DEST_PORT, {16'd0, dport});
        write_reg(CFG_IP_PROTOCOL, {24'd0, proto});
    endtask

    // stop sending, wait for every result, then let the pipeline settle
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // datagram of random words, mostly full words with odd bytes and empties mixed in
    task automatic random_datagram(input int max_words);
        int n;
        int pick;
        logic [1:0]  vb;
        logic [15:0] word;
        n = $urandom_range(1, max_words);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 15);
            if (pick < 10)
                vb = VB_BOTH;
            else if (pick < 12)
                vb = VB_HIGH;
            else if (pick < 14)
                vb = VB_NONE;
            else
                vb = VB_WIDE;
            case ($urandom_range(0, 7))
                0: word = 16'hFFFF;
                1: word = 16'h0000;
                default: word = 16'($urandom);
            endcase
            send_word(word, vb, i == n - 1);
        end
    endtask

    // datagram of a given byte length, odd lengths end on a single byte
    task automatic long_datagram(input int nbytes);
        int nwords;
        nwords = (nbytes + 1) / 2;
        for (int i = 0; i < nwords; i++)
            send_word(16'($urandom),
                      (i == nwords - 1 && nbytes % 2 == 1) ? VB_HIGH : VB_BOTH,
                      i == nwords - 1);
    endtask

    // main sequence
    initial begin
        board = new();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        source_idle = 1'b1;
        sink_idle   = 1'b1;

        // directed cases on the reset register values
        send_word(16'h0000, VB_NONE, 1'b1);     // empty payload
        send_word(16'hFFFF, VB_BOTH, 1'b1);
        send_word(16'h0000, VB_BOTH, 1'b1);
        send_word(16'hFFDA, VB_BOTH, 1'b1);     // sum lands on all ones, zero checksum
        // odd byte in the middle of the payload
        send_word(16'hAB12, VB_HIGH, 1'b0);
        send_word(16'h3456, VB_BOTH, 1'b0);
        send_word(16'h7800, VB_HIGH, 1'b0);
        send_word(16'h9ABC, VB_BOTH, 1'b1);
        // valid bytes three counts as a full word
        send_word(16'hFFFF, VB_WIDE, 1'b0);
        send_word(16'h0001, VB_WIDE, 1'b1);
        // empty word mid-stream, odd trailing byte
        send_word(16'h1234, VB_NONE, 1'b0);
        send_word(16'h5678, VB_BOTH, 1'b0);
        send_word(16'hC3A5, VB_HIGH, 1'b1);
        // odd byte followed by an empty last word
        send_word(16'h8000, VB_HIGH, 1'b0);
        send_word(16'h0000, VB_NONE, 1'b1);
        drain();

        // random datagrams under several register settings
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_config('0, '0, '0, '0, '0);
                1: load_config('1, '1, '1, '1, '1);
                default: load_config($urandom, $urandom, 16'($urandom), 16'($urandom),
                                     8'($urandom));
            endcase
            source_idle = ($urandom_range(0, 3) != 0);
            sink_idle   = ($urandom_range(0, 3) != 0);
            phase_items = 0;
            while (phase_items < 130)
                random_datagram(phase == 5 ? 40 : 12);
            drain();
        end

        // no idling from here: odd and even lengths back to back
        source_idle = 1'b0;
        sink_idle   = 1'b0;
        load_config($urandom, $urandom, 16'($urandom), 16'($urandom), IP_PROTO_UDP);
        long_datagram(41);
        long_datagram(40);
        phase_items = 0;
        while (phase_items < 30)
            random_datagram(12);
        drain();

        if (board.mismatches == 0 && board.pending() == 0)
            $display("udp_ipv4_header_checksum_gen_top_tb passed");
        else
            $display("udp_ipv4_header_checksum_gen_top_tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/udpcs_pkg.sv
sv/udpcs_front.sv
sv/udpcs_queue.sv
sv/udpcs_back.sv
sv/udpcs_engine.sv
sv/udp_ipv4_header_checksum_gen_top.sv
bench/udp_ipv4_header_checksum_gen_top_tb.sv
